[rtl/sbcl_pkg.sv]
// ----------------------------------------------------------------------------
// sbcl_pkg
// Shared types and constants for the smallest box containment lookup.
// ----------------------------------------------------------------------------
package sbcl_pkg;

  localparam int MAX_BOXES  = 256;
  localparam int COORD_BITS = 16;
  localparam int MSG_BITS   = 8;
  localparam int IDX_BITS   = $clog2(MAX_BOXES);
  localparam int CNT_BITS   = IDX_BITS + 1;
  localparam int VOL_BITS   = 3 * COORD_BITS;
  localparam int PROD_BITS  = 2 * COORD_BITS;
  localparam int DIST_BITS  = COORD_BITS + 4;
  localparam int NEAR_START = 10000000;
  localparam int NEAR_BITS  = $clog2(NEAR_START) + 1;
  localparam int GRAN_BITS  = 7;
  localparam int GRAN_RESET = 50;
  localparam int GRAN_MAX   = 64;
  localparam int CFG_BITS   = 7;
  localparam int CFGI_BITS  = 2;
  localparam int DIVC_BITS  = $clog2(COORD_BITS + 1);

  // register indexes
  localparam logic [CFGI_BITS-1:0] CFG_GRAN = 2'd0;
  localparam logic [CFGI_BITS-1:0] CFG_NEAR = 2'd1;
  localparam logic [CFGI_BITS-1:0] CFG_TEAM = 2'd2;

  // item kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // outcome codes
  localparam logic [2:0] OC_DONE   = 3'd0;
  localparam logic [2:0] OC_FULL   = 3'd1;
  localparam logic [2:0] OC_NONE   = 3'd2;
  localparam logic [2:0] OC_INSIDE = 3'd3;
  localparam logic [2:0] OC_NEAR   = 3'd4;

  typedef logic [2:0][COORD_BITS-1:0] coord3_t;

  typedef struct packed {
    logic [1:0]                   kind;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] bz;
    logic                         named;
    logic [MSG_BITS-1:0]          msg_a;
    logic [MSG_BITS-1:0]          msg_b;
    logic [MSG_BITS-1:0]          msg_c;
    logic [MSG_BITS-1:0]          msg_d;
  } in_word_t;

  typedef struct packed {
    logic [2:0]          outcome;
    logic [7:0]          box_index;
    logic                box_named;
    logic [MSG_BITS-1:0] message_number;
  } out_word_t;

  typedef struct packed {
    logic                     named;
    logic [3:0][MSG_BITS-1:0] msg;
  } label_t;

  typedef struct packed {
    coord3_t             lo;
    coord3_t             hi;
    logic [VOL_BITS-1:0] volume;
    label_t              label;
  } entry_t;

endpackage

[rtl/smallest_box_containment_lookup_top.sv]
// ----------------------------------------------------------------------------
// smallest_box_containment_lookup_top
// Box table with smallest-volume containment query and nearest-box fallback.
// ----------------------------------------------------------------------------
// Timing: clear, unused kinds and an append to a full table answer in the
// cycle after start and never raise busy. An append stays busy through the
// two multiplier stages; the table write lands once the second stage holds
// the volume. A query stays busy through the position divide (one quotient
// bit per cycle) and then a table pass; a second pass runs when nothing
// contains the position and the fallback is on. The single table read port,
// one entry per cycle, sets the pass length. Results show on out_data for
// one cycle with out_valid and cannot be held off; nothing follows until
// busy drops.
module smallest_box_containment_lookup_top import sbcl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_word_t             in_data,
  output logic                 out_valid,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFGI_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_NEAR = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [CNT_BITS-1:0]  box_count_r, count_nxt;
  logic [CNT_BITS-1:0]  rd_idx_r, rd_idx_nxt;
  logic [GRAN_BITS-1:0] gran_r, gran_clamp;
  logic                 near_r;
  logic [1:0]           team_r;

  logic                 accept;
  logic                 rd_en, mem_we, div_start, mul_start, div_done, mul_done;
  entry_t               rd_data, wr_data;
  logic [VOL_BITS-1:0]  mul_vol;
  coord3_t              pos, in_a, in_b, app_lo, app_hi, app_ext;
  label_t               in_label, app_label_r;
  coord3_t              app_lo_r, app_hi_r;

  // scan pipeline
  logic                 s1_vld_r;
  logic [IDX_BITS-1:0]  s1_idx_r, s2_idx_r;
  logic                 s2_vld_r;
  logic [2:0]           s2_in_r, in_ax;
  logic signed [DIST_BITS-1:0] s2_e_r [3];
  logic signed [DIST_BITS-1:0] e_ax [3];
  logic [VOL_BITS-1:0]  s2_vol_r;
  label_t               s2_label_r;

  logic                 found_r, found_nxt;
  logic [IDX_BITS-1:0]  best_idx_r, best_idx_nxt;
  logic [VOL_BITS-1:0]  best_vol_r, best_vol_nxt;
  logic signed [NEAR_BITS-1:0] best_d_r, best_d_nxt;
  label_t               best_label_r, best_label_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_data_r, out_data_nxt;

  logic signed [DIST_BITS-1:0] dmax;
  logic                 pass_end;
  logic [2:0]           hit_oc;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gran_r <= GRAN_BITS'(GRAN_RESET);
      near_r <= 1'b0;
      team_r <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRAN: gran_r <= cfg_data[GRAN_BITS-1:0];
        CFG_NEAR: near_r <= cfg_data[0];
        CFG_TEAM: team_r <= cfg_data[1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    if (gran_r == '0) begin
      gran_clamp = GRAN_BITS'(1);
    end else if (gran_r > GRAN_BITS'(GRAN_MAX)) begin
      gran_clamp = GRAN_BITS'(GRAN_MAX);
    end else begin
      gran_clamp = gran_r;
    end
  end

  // append: order corners and extents
  always_comb begin
    in_a = {in_data.az, in_data.ay, in_data.ax};
    in_b = {in_data.bz, in_data.by, in_data.bx};
    for (int a = 0; a < 3; a++) begin
      if ($signed(in_a[a]) < $signed(in_b[a])) begin
        app_lo[a] = in_a[a];
        app_hi[a] = in_b[a];
      end else begin
        app_lo[a] = in_b[a];
        app_hi[a] = in_a[a];
      end
      app_ext[a] = app_hi[a] - app_lo[a];
    end
    in_label.named  = in_data.named;
    in_label.msg[0] = in_data.msg_a;
    in_label.msg[1] = in_data.msg_b;
    in_label.msg[2] = in_data.msg_c;
    in_label.msg[3] = in_data.msg_d;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      app_lo_r    <= app_lo;
      app_hi_r    <= app_hi;
      app_label_r <= in_label;
    end
  end

  assign wr_data = '{lo: app_lo_r, hi: app_hi_r, volume: mul_vol, label: app_label_r};

  sbcl_vol_mul u_vol_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .ext   (app_ext),
    .done  (mul_done),
    .vol   (mul_vol)
  );

  sbcl_pos_div u_pos_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_a),
    .divisor  (gran_clamp),
    .done     (div_done),
    .quotient (pos)
  );

  sbcl_box_mem u_box_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (box_count_r[IDX_BITS-1:0]),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_idx_r[IDX_BITS-1:0]),
    .rdata (rd_data)
  );

  // stage a: per-axis containment and box distance of the entry just read
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [DIST_BITS-1:0] p, lo, hi, t, m;
      p  = DIST_BITS'($signed(pos[a]));
      lo = DIST_BITS'($signed(rd_data.lo[a]));
      hi = DIST_BITS'($signed(rd_data.hi[a]));
      t  = (p <<< 1) - lo - hi;
      m  = (t < 0) ? -t : t;
      e_ax[a]  = m - (hi - lo);
      in_ax[a] = (p >= lo) && (p < hi);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= rd_en;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r   <= rd_idx_r[IDX_BITS-1:0];
    s2_idx_r   <= s1_idx_r;
    s2_in_r    <= in_ax;
    s2_vol_r   <= rd_data.volume;
    s2_label_r <= rd_data.label;
    for (int a = 0; a < 3; a++) begin
      s2_e_r[a] <= e_ax[a];
    end
  end

  always_comb begin
    dmax = s2_e_r[0];
    if (s2_e_r[1] > dmax) begin
      dmax = s2_e_r[1];
    end
    if (s2_e_r[2] > dmax) begin
      dmax = s2_e_r[2];
    end
  end

  // stage b and sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = box_count_r;
    rd_idx_nxt     = rd_idx_r;
    rd_en          = 1'b0;
    mem_we         = 1'b0;
    div_start      = 1'b0;
    mul_start      = 1'b0;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_vol_nxt   = best_vol_r;
    best_d_nxt     = best_d_r;
    best_label_nxt = best_label_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    pass_end       = (rd_idx_r == box_count_r) && !s1_vld_r && !s2_vld_r;
    hit_oc         = OC_NONE;

    if (s2_vld_r) begin
      if (state_r == ST_SCAN) begin
        if ((&s2_in_r) && (!found_r || (s2_vol_r < best_vol_r))) begin
          found_nxt      = 1'b1;
          best_idx_nxt   = s2_idx_r;
          best_vol_nxt   = s2_vol_r;
          best_label_nxt = s2_label_r;
        end
      end else if (NEAR_BITS'(dmax) < best_d_r) begin
        found_nxt      = 1'b1;
        best_idx_nxt   = s2_idx_r;
        best_d_nxt     = NEAR_BITS'(dmax);
        best_label_nxt = s2_label_r;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_data_nxt = '0;
          priority case (in_data.kind)
            KIND_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_data_nxt.outcome = OC_DONE;
            end
            KIND_APPEND: begin
              if (box_count_r >= CNT_BITS'(MAX_BOXES)) begin
                out_valid_nxt = 1'b1;
                out_data_nxt.outcome = OC_FULL;
              end else begin
                mul_start = 1'b1;
                state_nxt = ST_MUL;
              end
            end
            KIND_QUERY: begin
              div_start = 1'b1;
              found_nxt = 1'b0;
              state_nxt = ST_DIV;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt.outcome = OC_DONE;
            end
          endcase
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          mem_we        = 1'b1;
          count_nxt     = box_count_r + 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.outcome = OC_DONE;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          rd_idx_nxt = '0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN, ST_NEAR: begin
        if (rd_idx_r < box_count_r) begin
          rd_en      = 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        hit_oc = (state_r == ST_SCAN) ? OC_INSIDE : OC_NEAR;
        if (pass_end) begin
          if (state_r == ST_SCAN && !found_r && near_r) begin
            rd_idx_nxt = '0;
            best_d_nxt = NEAR_BITS'(NEAR_START);
            state_nxt  = ST_NEAR;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            state_nxt     = ST_IDLE;
            if (found_r) begin
              out_data_nxt.outcome   = hit_oc;
              out_data_nxt.box_index = 8'(best_idx_r);
              out_data_nxt.box_named = best_label_r.named;
              out_data_nxt.message_number =
                best_label_r.named ? '0 : best_label_r.msg[team_r];
            end else begin
              out_data_nxt.outcome = OC_NONE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      box_count_r <= '0;
      rd_idx_r    <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      box_count_r <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r   <= best_idx_nxt;
    best_vol_r   <= best_vol_nxt;
    best_d_r     <= best_d_nxt;
    best_label_r <= best_label_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a word goes out only when the block is ready for the next one
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // every accepted word either answers at once or keeps the block busy
  a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted word dropped");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    box_count_r <= CNT_BITS'(MAX_BOXES))
    else $error("box count past table size");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (box_count_r < CNT_BITS'(MAX_BOXES)) && !rd_en)
    else $error("table write without room or during scan");

endmodule

[rtl/sbcl_box_mem.sv]
// ----------------------------------------------------------------------------
// sbcl_box_mem
// Box table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sbcl_box_mem import sbcl_pkg::*; (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_BITS-1:0] waddr,
  input  entry_t              wdata,
  input  logic                re,
  input  logic [IDX_BITS-1:0] raddr,
  output entry_t              rdata
);

  entry_t mem [MAX_BOXES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/sbcl_pos_div.sv]
// ----------------------------------------------------------------------------
// sbcl_pos_div
// Three-lane restoring divider, one quotient bit per cycle, truncates
// toward zero.
// ----------------------------------------------------------------------------
module sbcl_pos_div import sbcl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  coord3_t              dividend,
  input  logic [GRAN_BITS-1:0] divisor,
  output logic                 done,
  output coord3_t              quotient
);

  logic [DIVC_BITS-1:0]  cnt_r, cnt_nxt;
  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [GRAN_BITS-1:0]  dvs_r;
  logic [2:0]            neg_r;
  coord3_t               quo_r, quo_nxt;
  logic [GRAN_BITS-1:0]  rem_r [3];
  logic [GRAN_BITS-1:0]  rem_nxt [3];
  logic [GRAN_BITS:0]    trial;
  logic [COORD_BITS-1:0] mag;

  always_comb begin
    quo_nxt = quo_r;
    for (int a = 0; a < 3; a++) begin
      rem_nxt[a] = rem_r[a];
      trial = {rem_r[a], quo_r[a][COORD_BITS-1]};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt[a] = GRAN_BITS'(trial - {1'b0, dvs_r});
        quo_nxt[a] = {quo_r[a][COORD_BITS-2:0], 1'b1};
      end else begin
        rem_nxt[a] = trial[GRAN_BITS-1:0];
        quo_nxt[a] = {quo_r[a][COORD_BITS-2:0], 1'b0};
      end
    end
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIVC_BITS'(COORD_BITS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      for (int a = 0; a < 3; a++) begin
        neg_r[a] <= dividend[a][COORD_BITS-1];
        rem_r[a] <= '0;
        // magnitude; the most negative value wraps to its own unsigned value
        quo_r[a] <= dividend[a][COORD_BITS-1] ? (~dividend[a] + 1'b1) : dividend[a];
      end
    end else if (run_r) begin
      quo_r <= quo_nxt;
      for (int a = 0; a < 3; a++) begin
        rem_r[a] <= rem_nxt[a];
      end
    end
  end

  always_comb begin
    quotient = '0;
    for (int a = 0; a < 3; a++) begin
      mag = quo_r[a];
      quotient[a] = neg_r[a] ? (~mag + 1'b1) : mag;
    end
  end

  assign done = done_r;

endmodule

[rtl/sbcl_vol_mul.sv]
// ----------------------------------------------------------------------------
// sbcl_vol_mul
// Two-stage exact box volume: extent x times y, then times z.
// ----------------------------------------------------------------------------
module sbcl_vol_mul import sbcl_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  coord3_t             ext,
  output logic                done,
  output logic [VOL_BITS-1:0] vol
);

  logic                  v1_r, done_r;
  logic [PROD_BITS-1:0]  p1_r;
  logic [COORD_BITS-1:0] ez_r;
  logic [VOL_BITS-1:0]   vol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      done_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r  <= PROD_BITS'(ext[0]) * PROD_BITS'(ext[1]);
    ez_r  <= ext[2];
    vol_r <= VOL_BITS'(p1_r) * VOL_BITS'(ez_r);
  end

  assign done = done_r;
  assign vol  = vol_r;

endmodule
